FILE: sv/touch_gesture_recognizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Touch gesture recognizer assertion macros
// Concurrent assertion forms used by the recognizer back end.
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_RECOGNIZER_UNIT_ASSERT_SVH
`define TOUCH_GESTURE_RECOGNIZER_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define TGR_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that must lead to a consequence in the next cycle.
`define TGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/tgr_pkg.sv
// ----------------------------------------------------------------------------
// Touch gesture recognizer package
// Types, codes and register indexes shared by the recognizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

	localparam int unsigned COORD_W = 12;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_TDATA_W = 72;
	localparam int unsigned OUT_TDATA_W = 8;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_SWIPE_MIN_DISTANCE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SWIPE_MAX_TIME = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_NEAR = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_FAR = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TIME = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_MAX_MOVE = 3'd5;

	typedef enum logic [1:0] {
		GEST_NONE = 2'd0,
		GEST_LONG_PRESS = 2'd1,
		GEST_SWIPE = 2'd2
	} gesture_t;

	typedef enum logic [3:0] {
		ZONE_NONE = 4'd0,
		ZONE_TOP_LEFT = 4'd1,
		ZONE_TOP_RIGHT = 4'd2,
		ZONE_BOTTOM_LEFT = 4'd3,
		ZONE_BOTTOM_RIGHT = 4'd4,
		ZONE_TOP = 4'd5,
		ZONE_BOTTOM = 4'd6,
		ZONE_LEFT = 4'd7,
		ZONE_RIGHT = 4'd8
	} zone_t;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_LEFT = 2'd1,
		DIR_DOWN = 2'd2,
		DIR_UP = 2'd3
	} dir_t;

	typedef struct packed {
		logic               touched;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [TIME_W-1:0]  time_ms;
	} item_t;

	typedef struct packed {
		logic               push;
		logic               full;
	} queue_ctl_t;

endpackage

`default_nettype wire

FILE: sv/tgr_front.sv
// ----------------------------------------------------------------------------
// Touch gesture recognizer front end
// Accepts touch reports, decodes coordinates and classifies touch or release.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_front (
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [tgr_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  wire tgr_pkg::queue_ctl_t              q_status,
	output tgr_pkg::queue_ctl_t                   q_ctl,
	output tgr_pkg::item_t                        item
);
	import tgr_pkg::*;

	logic [7:0] finger_count;
	logic [7:0] x_high_byte;
	logic [7:0] x_low_byte;
	logic [7:0] y_high_byte;
	logic [7:0] y_low_byte;

	assign finger_count = s_tdata[7:0];
	assign x_high_byte = s_tdata[15:8];
	assign x_low_byte = s_tdata[23:16];
	assign y_high_byte = s_tdata[31:24];
	assign y_low_byte = s_tdata[39:32];

	// Flag bits in the upper nibble of the high bytes are dropped.
	assign item.touched = (finger_count != 8'd0);
	assign item.x = {x_high_byte[3:0], x_low_byte};
	assign item.y = {y_high_byte[3:0], y_low_byte};
	assign item.time_ms = s_tdata[71:40];

	assign s_tready = !q_status.full;
	assign q_ctl.push = s_tvalid && !q_status.full;
	assign q_ctl.full = q_status.full;

endmodule

`default_nettype wire

FILE: sv/tgr_queue.sv
// ----------------------------------------------------------------------------
// Touch gesture recognizer item queue
// Short FIFO that decouples the front end from the gesture back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tgr_pkg::queue_ctl_t  q_ctl,
	input  wire tgr_pkg::item_t       push_item,
	input  wire logic                 pop,
	output logic                      q_valid,
	output tgr_pkg::item_t            q_item,
	output tgr_pkg::queue_ctl_t       q_status
);
	import tgr_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push = q_ctl.push && (count_q != DEPTH_CNT);
	assign do_pop = pop && (count_q != '0);

	assign q_valid = (count_q != '0);
	assign q_item = mem_q[rd_ptr_q];
	assign q_status.full = (count_q == DEPTH_CNT);
	assign q_status.push = do_push;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/tgr_back.sv
// ----------------------------------------------------------------------------
// Touch gesture recognizer back end
// Tracks the touch, detects long presses and swipes, registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_gesture_recognizer_unit_assert.svh"

module tgr_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wen,
	input  wire logic [tgr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [tgr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              q_valid,
	input  wire tgr_pkg::item_t                    q_item,
	output logic                                   pop,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [tgr_pkg::OUT_TDATA_W-1:0]        m_tdata
);
	import tgr_pkg::*;

	logic [COORD_W-1:0] swipe_min_distance_q;
	logic [15:0]        swipe_max_time_q;
	logic [COORD_W-1:0] edge_near_q;
	logic [COORD_W-1:0] edge_far_q;
	logic [15:0]        hold_time_q;
	logic [COORD_W-1:0] hold_max_move_q;

	logic               touch_active_q;
	logic               long_press_done_q;
	logic [COORD_W-1:0] start_x_q;
	logic [COORD_W-1:0] start_y_q;
	logic [TIME_W-1:0]  start_time_q;
	logic [COORD_W-1:0] last_x_q;
	logic [COORD_W-1:0] last_y_q;

	logic               out_valid_q;
	gesture_t           gesture_q;
	zone_t              zone_q;
	dir_t               dir_q;

	logic [COORD_W-1:0] ref_x;
	logic [COORD_W-1:0] ref_y;
	logic [TIME_W-1:0]  ref_time;
	logic               lpd_eff;
	logic [COORD_W-1:0] pos_x;
	logic [COORD_W-1:0] pos_y;
	logic               x_up;
	logic               y_up;
	logic [COORD_W-1:0] ax;
	logic [COORD_W-1:0] ay;
	logic [TIME_W-1:0]  dur;
	logic               long_press;
	logic               swipe;
	gesture_t           gesture_d;
	zone_t              zone_d;
	dir_t               dir_d;
	logic               zt;
	logic               zb;
	logic               zl;
	logic               zr;

	assign pop = q_valid && (!out_valid_q || m_tready);

	// On the first touched report the start point is the report itself.
	assign ref_x = touch_active_q ? start_x_q : q_item.x;
	assign ref_y = touch_active_q ? start_y_q : q_item.y;
	assign ref_time = touch_active_q ? start_time_q : q_item.time_ms;
	assign lpd_eff = touch_active_q && long_press_done_q;

	assign pos_x = q_item.touched ? q_item.x : last_x_q;
	assign pos_y = q_item.touched ? q_item.y : last_y_q;
	assign x_up = (pos_x > ref_x);
	assign y_up = (pos_y > ref_y);
	assign ax = x_up ? (pos_x - ref_x) : (ref_x - pos_x);
	assign ay = y_up ? (pos_y - ref_y) : (ref_y - pos_y);
	assign dur = q_item.time_ms - ref_time;

	assign long_press = q_item.touched && !lpd_eff
		&& (dur > {16'd0, hold_time_q})
		&& (ax < hold_max_move_q) && (ay < hold_max_move_q);
	assign swipe = !q_item.touched && touch_active_q
		&& (dur < {16'd0, swipe_max_time_q})
		&& ((ax > swipe_min_distance_q) || (ay > swipe_min_distance_q));

	assign zt = (start_y_q < edge_near_q);
	assign zb = (start_y_q > edge_far_q);
	assign zl = (start_x_q < edge_near_q);
	assign zr = (start_x_q > edge_far_q);

	always_comb begin
		gesture_d = GEST_NONE;
		zone_d = ZONE_NONE;
		dir_d = DIR_RIGHT;
		if (long_press) begin
			gesture_d = GEST_LONG_PRESS;
		end else if (swipe) begin
			gesture_d = GEST_SWIPE;
			priority if (zt && zl) begin
				zone_d = ZONE_TOP_LEFT;
			end else if (zt && zr) begin
				zone_d = ZONE_TOP_RIGHT;
			end else if (zb && zl) begin
				zone_d = ZONE_BOTTOM_LEFT;
			end else if (zb && zr) begin
				zone_d = ZONE_BOTTOM_RIGHT;
			end else if (zt) begin
				zone_d = ZONE_TOP;
			end else if (zb) begin
				zone_d = ZONE_BOTTOM;
			end else if (zl) begin
				zone_d = ZONE_LEFT;
			end else if (zr) begin
				zone_d = ZONE_RIGHT;
			end else begin
				zone_d = ZONE_NONE;
			end
			if (ax > ay) begin
				dir_d = x_up ? DIR_RIGHT : DIR_LEFT;
			end else begin
				dir_d = y_up ? DIR_DOWN : DIR_UP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swipe_min_distance_q <= 12'd50;
			swipe_max_time_q <= 16'd800;
			edge_near_q <= 12'd100;
			edge_far_q <= 12'd380;
			hold_time_q <= 16'd500;
			hold_max_move_q <= 12'd20;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_SWIPE_MIN_DISTANCE: swipe_min_distance_q <= cfg_data[COORD_W-1:0];
				CFG_SWIPE_MAX_TIME: swipe_max_time_q <= cfg_data;
				CFG_EDGE_NEAR: edge_near_q <= cfg_data[COORD_W-1:0];
				CFG_EDGE_FAR: edge_far_q <= cfg_data[COORD_W-1:0];
				CFG_HOLD_TIME: hold_time_q <= cfg_data;
				CFG_HOLD_MAX_MOVE: hold_max_move_q <= cfg_data[COORD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_active_q <= 1'b0;
			long_press_done_q <= 1'b0;
			start_x_q <= '0;
			start_y_q <= '0;
			start_time_q <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (pop) begin
			if (q_item.touched) begin
				touch_active_q <= 1'b1;
				start_x_q <= ref_x;
				start_y_q <= ref_y;
				start_time_q <= ref_time;
				last_x_q <= q_item.x;
				last_y_q <= q_item.y;
				long_press_done_q <= lpd_eff || long_press;
			end else begin
				touch_active_q <= 1'b0;
				long_press_done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			gesture_q <= gesture_d;
			zone_q <= zone_d;
			dir_q <= dir_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {dir_q, zone_q, gesture_q};

	`TGR_ASSERT_HOLDS(a_long_press_clean, clk, arst_n,
		(out_valid_q && gesture_q == GEST_LONG_PRESS) |->
		(zone_q == ZONE_NONE && dir_q == DIR_RIGHT), "long press with zone or direction")
	`TGR_ASSERT_NEXT(a_release_clears, clk, arst_n, pop && !q_item.touched,
		!touch_active_q && !long_press_done_q, "release left touch state set")
	`TGR_ASSERT_HOLDS(a_lpd_needs_touch, clk, arst_n,
		long_press_done_q |-> touch_active_q, "long press marked without touch")
	`TGR_ASSERT_NEXT(a_swipe_from_release, clk, arst_n,
		pop && q_item.touched, gesture_q != GEST_SWIPE, "swipe on a touched report")

endmodule

`default_nettype wire

FILE: sv/touch_gesture_recognizer_unit.sv
// ----------------------------------------------------------------------------
// Touch gesture recognizer
// Turns a stream of touch reports into long press and swipe events.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                         | contents
//  s_*      | in        | s_tvalid s_tready s_tdata[71:0] | touch report
//  m_*      | out       | m_tvalid m_tready m_tdata[7:0]  | gesture result
//  cfg_*    | in        | cfg_wen cfg_index cfg_data      | register write
//
// One report is taken per cycle while s_tready is high, and each gives exactly one result.
// An accepted report waits in the two-entry queue until the gesture stage, which
// also updates the touch state, pops it and registers its result for m_tvalid.
// A stalled output holds its result; the queue keeps taking reports until
// both entries are in use, then s_tready drops.
// Reset restores all register defaults and clears the touch state at once.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_gesture_recognizer_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// finger_count, x_high_byte, x_low_byte, y_high_byte, y_low_byte, time_ms
	input  wire logic [tgr_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// gesture, start_zone, swipe_direction
	output logic [tgr_pkg::OUT_TDATA_W-1:0]        m_tdata,
	input  wire logic                              cfg_wen,
	input  wire logic [tgr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [tgr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tgr_pkg::*;

	queue_ctl_t q_ctl;
	queue_ctl_t q_status;
	item_t      front_item;
	item_t      q_item;
	logic       q_valid;
	logic       pop;

	tgr_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_status (q_status),
		.q_ctl    (q_ctl),
		.item     (front_item)
	);

	tgr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_ctl     (q_ctl),
		.push_item (front_item),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_status  (q_status)
	);

	tgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire
